// ===== rtl/ptr_pkg.sv =====
package ptr_pkg;

  // Item kinds carried on the slave tuser lane.
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Register offsets within the timer block.
  localparam logic [3:0] OFF_DIV   = 4'd4;
  localparam logic [3:0] OFF_CNT   = 4'd5;
  localparam logic [3:0] OFF_MOD   = 4'd6;
  localparam logic [3:0] OFF_CTRL  = 4'd7;
  localparam logic [3:0] OFF_FLAGS = 4'd15;

  // Bits ORed into the flags register when the counter wraps.
  localparam logic [7:0] FLAG_SET = 8'hE4;

  // Control register fields.
  localparam int unsigned CTRL_EN_BIT = 2;

  localparam int unsigned CF_W   = 11;
  localparam int unsigned CF_ACC = CF_W + 1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COUNT,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic count_step;
    logic count_end;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       is_tick;
    logic       cnt_en;
    logic       cf_ge;
    logic       wrapped;
    logic [7:0] irq_flags;
  } dp_status_t;

  // Counter period in ticks for the two select bits of the control register.
  function automatic logic [CF_ACC-1:0] period_of(input logic [1:0] sel);
    logic [CF_ACC-1:0] p;
    case (sel)
      2'd0:    p = 12'd1024;
      2'd1:    p = 12'd16;
      2'd2:    p = 12'd64;
      default: p = 12'd256;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/ptr_ctrl.sv =====
module ptr_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  ptr_pkg::dp_status_t    status_i,
  output ptr_pkg::ctrl_cmd_t     cmd_o,
  output ptr_pkg::state_e        state_o
);

  ptr_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  // State and result-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ptr_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ptr_pkg::ST_EXEC;
        end
      end
      ptr_pkg::ST_EXEC: begin
        if (status_i.is_tick && status_i.cnt_en) begin
          state_d = ptr_pkg::ST_COUNT;
        end else begin
          state_d = ptr_pkg::ST_DONE;
        end
      end
      ptr_pkg::ST_COUNT: begin
        if (!status_i.cf_ge) begin
          state_d = ptr_pkg::ST_DONE;
        end
      end
      ptr_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ptr_pkg::ST_IDLE;
        end
      end
      default: state_d = ptr_pkg::ST_IDLE;
    endcase
  end

  // Output decode: datapath commands and handshake signals.
  always_comb begin
    cmd_o            = '0;
    cmd_o.capture    = (state_q == ptr_pkg::ST_IDLE) && s_axis_tvalid;
    cmd_o.exec       = (state_q == ptr_pkg::ST_EXEC);
    cmd_o.count_step = (state_q == ptr_pkg::ST_COUNT) && status_i.cf_ge;
    cmd_o.count_end  = (state_q == ptr_pkg::ST_COUNT) && !status_i.cf_ge;
    cmd_o.load_out   = (state_q == ptr_pkg::ST_DONE) && (!out_valid_q || m_axis_tready);
    s_axis_tready    = (state_q == ptr_pkg::ST_IDLE);
  end

  // The result word stays valid until taken unless a fresh one replaces it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign state_o       = state_q;

endmodule

// ===== rtl/ptr_dp.sv =====
module ptr_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          item_cmd_i,
  input  logic [23:0]         item_data_i,
  input  ptr_pkg::ctrl_cmd_t  cmd_i,
  output ptr_pkg::dp_status_t status_o,
  output logic [15:0]         out_data_o
);

  // Captured item.
  ptr_pkg::cmd_e kind_q;
  logic [3:0]    off_q;
  logic [7:0]    wdata_q;
  logic [7:0]    ticks_q;

  // Timer registers.
  logic [7:0]              div_q;
  logic [7:0]              div_frac_q;
  logic [7:0]              cnt_q;
  logic [ptr_pkg::CF_W-1:0] cnt_frac_q;
  logic [7:0]              mod_q;
  logic [7:0]              ctrl_q;
  logic [7:0]              flags_q;

  // Working state for the current item.
  logic [ptr_pkg::CF_ACC-1:0] acc_q;
  logic [7:0]                 rd_q;
  logic                       wrapped_q;
  logic [8:0]                 out_q;

  logic [ptr_pkg::CF_ACC-1:0] period;
  logic [8:0]                 div_sum;
  logic [7:0]                 rd_mux;

  assign period  = ptr_pkg::period_of(ctrl_q[1:0]);
  assign div_sum = {1'b0, div_frac_q} + {1'b0, ticks_q};

  // Register read mux; unmapped offsets read as zero.
  always_comb begin
    case (off_q)
      ptr_pkg::OFF_DIV:   rd_mux = div_q;
      ptr_pkg::OFF_CNT:   rd_mux = cnt_q;
      ptr_pkg::OFF_MOD:   rd_mux = mod_q;
      ptr_pkg::OFF_CTRL:  rd_mux = ctrl_q;
      ptr_pkg::OFF_FLAGS: rd_mux = flags_q;
      default:            rd_mux = 8'd0;
    endcase
  end

  // Item capture and result word; payload only, no reset needed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= ptr_pkg::cmd_e'(item_cmd_i);
      off_q   <= item_data_i[3:0];
      wdata_q <= item_data_i[11:4];
      ticks_q <= item_data_i[19:12];
    end
    if (cmd_i.load_out) begin
      out_q <= {wrapped_q, rd_q};
    end
  end

  // Timer registers and the increment loop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q      <= '0;
      div_frac_q <= '0;
      cnt_q      <= '0;
      cnt_frac_q <= '0;
      mod_q      <= '0;
      ctrl_q     <= '0;
      flags_q    <= '0;
      acc_q      <= '0;
      rd_q       <= '0;
      wrapped_q  <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        rd_q      <= (kind_q == ptr_pkg::CMD_READ) ? rd_mux : 8'd0;
        wrapped_q <= 1'b0;
        if (kind_q == ptr_pkg::CMD_WRITE) begin
          case (off_q)
            ptr_pkg::OFF_DIV:   div_q   <= 8'd0;
            ptr_pkg::OFF_CNT:   cnt_q   <= wdata_q;
            ptr_pkg::OFF_MOD:   mod_q   <= wdata_q;
            ptr_pkg::OFF_CTRL:  ctrl_q  <= wdata_q;
            ptr_pkg::OFF_FLAGS: flags_q <= wdata_q;
            default: ;
          endcase
        end
        if (kind_q == ptr_pkg::CMD_TICK) begin
          // The divider steps at most once per tick; the carry is that step.
          div_frac_q <= div_sum[7:0];
          div_q      <= div_q + {7'd0, div_sum[8]};
          acc_q      <= {1'b0, cnt_frac_q} + {4'd0, ticks_q};
        end
      end
      // One counter increment per cycle while a full period remains.
      if (cmd_i.count_step) begin
        acc_q <= acc_q - period;
        if (cnt_q == 8'hFF) begin
          cnt_q     <= mod_q;
          flags_q   <= flags_q | ptr_pkg::FLAG_SET;
          wrapped_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 8'd1;
        end
      end
      if (cmd_i.count_end) begin
        cnt_frac_q <= acc_q[ptr_pkg::CF_W-1:0];
      end
    end
  end

  always_comb begin
    status_o           = '0;
    status_o.is_tick   = (kind_q == ptr_pkg::CMD_TICK);
    status_o.cnt_en    = ctrl_q[ptr_pkg::CTRL_EN_BIT];
    status_o.cf_ge     = (acc_q >= period);
    status_o.wrapped   = wrapped_q;
    status_o.irq_flags = flags_q;
  end

  assign out_data_o = {7'd0, out_q};

endmodule

// ===== rtl/prescaled_timer_with_reload_top.sv =====
// A read, a write or a tick with the counter disabled is captured in IDLE, executed in
// EXEC and loaded as its result word in DONE; an enabled tick passes through COUNT
// between EXEC and DONE, one counter increment per cycle in the step loop.
// One item is handled at a time; the next item is accepted while a result waits.
// Reset: rst_ni is asynchronous, active low, and clears all timer registers to zero.
module prescaled_timer_with_reload_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [3:0] reg_offset, [11:4] write_data, [19:12] tick_count
  input  logic [1:0]  s_axis_tuser,  // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // [7:0] read_data, [8] overflow_irq
);

  ptr_pkg::ctrl_cmd_t  cmd;
  ptr_pkg::dp_status_t status;
  ptr_pkg::state_e     state;

  // Controller: sequences each item and owns the handshakes.
  ptr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd),
    .state_o       (state)
  );

  // Datapath: timer registers, increment loop and result word.
  ptr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_cmd_i  (s_axis_tuser),
    .item_data_i (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (m_axis_tdata)
  );

  // A wrap reported in the result word must have raised the flag bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out && status.wrapped |=>
      ((status.irq_flags & ptr_pkg::FLAG_SET) == ptr_pkg::FLAG_SET))
    else $error("wrap reported without flags set");

  // The step loop finishes only once less than a full period remains.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == ptr_pkg::ST_COUNT) && !status.cf_ge |=> (state == ptr_pkg::ST_DONE))
    else $error("step loop did not finish");

  // A new result word may only be loaded when the previous one is gone or taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result word overwritten");

endmodule

// ===== tb/prescaled_timer_with_reload_top_tb.sv =====
module prescaled_timer_with_reload_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 64;

  // Counter period in ticks, indexed by control bits 1..0.
  localparam int unsigned TICK_PERIOD [4] = '{1024, 16, 64, 256};

  // One expected result word.
  typedef struct packed {
    logic [7:0] rd;
    logic       irq;
  } timer_reply_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;  // [3:0] reg_offset, [11:4] write_data, [19:12] tick_count
  logic [1:0]  s_axis_tuser;  // [1:0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;  // [7:0] read_data, [8] overflow_irq

  // Predicted timer registers.
  logic [7:0]  tm_div;
  logic [7:0]  tm_div_frac;
  logic [7:0]  tm_cnt;
  logic [10:0] tm_cnt_frac;
  logic [7:0]  tm_mod;
  logic [7:0]  tm_ctrl;
  logic [7:0]  tm_flags;

  timer_reply_t timer_replies[$];
  timer_reply_t want_reply;

  int unsigned send_idle_pct;
  int unsigned rcv_stall_pct;
  logic        rcv_hold;
  int unsigned cycle_count;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_wraps;
  int unsigned fail_count;

  prescaled_timer_with_reload_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Free-running 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one item to the predicted registers and returns its result word.
  function automatic timer_reply_t timer_step(input cmd_e cmd, input logic [3:0] off,
                                              input logic [7:0] wdata,
                                              input logic [7:0] ticks);
    timer_reply_t r;
    int unsigned  df;
    int unsigned  cf;
    int unsigned  per;
    r = '0;
    case (cmd)
      CMD_READ: begin
        case (off)
          OFF_DIV:   r.rd = tm_div;
          OFF_CNT:   r.rd = tm_cnt;
          OFF_MOD:   r.rd = tm_mod;
          OFF_CTRL:  r.rd = tm_ctrl;
          OFF_FLAGS: r.rd = tm_flags;
          default:   r.rd = 8'h00;
        endcase
      end
      CMD_WRITE: begin
        case (off)
          OFF_DIV:   tm_div = 8'h00;
          OFF_CNT:   tm_cnt = wdata;
          OFF_MOD:   tm_mod = wdata;
          OFF_CTRL:  tm_ctrl = wdata;
          OFF_FLAGS: tm_flags = wdata;
          default: ;
        endcase
      end
      CMD_TICK: begin
        // The divider moves at most once per tick.
        df = 32'(tm_div_frac) + 32'(ticks);
        if (df >= 256) begin
          tm_div = tm_div + 8'd1;
          df = df - 256;
        end
        tm_div_frac = df[7:0];
        // The counter drains its whole fraction, one step per period.
        if (tm_ctrl[CTRL_EN_BIT]) begin
          per = TICK_PERIOD[tm_ctrl[1:0]];
          cf = 32'(tm_cnt_frac) + 32'(ticks);
          while (cf >= per) begin
            cf = cf - per;
            tm_cnt = tm_cnt + 8'd1;
            if (tm_cnt == 8'h00) begin
              tm_flags = tm_flags | FLAG_SET;
              tm_cnt = tm_mod;
              r.irq = 1'b1;
            end
          end
          tm_cnt_frac = cf[10:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offers one word, optionally after idle cycles, and records its expected result.
  task automatic send_word(input cmd_e cmd, input logic [3:0] off, input logic [7:0] wdata,
                           input logic [7:0] ticks);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'h0, ticks, wdata, off};
    do @(posedge clk_i); while (!s_axis_tready);
    timer_replies.push_back(timer_step(cmd, off, wdata, ticks));
    if (timer_replies[$].irq) n_wraps++;
    n_sent++;
  endtask

  // Builds one random word, biased towards mapped registers and ticks.
  task automatic send_random_word();
    int unsigned pick;
    cmd_e        cmd;
    logic [3:0]  off;
    logic [7:0]  wdata;
    logic [7:0]  ticks;
    pick = $urandom_range(99);
    if (pick < 45) cmd = CMD_TICK;
    else if (pick < 70) cmd = CMD_READ;
    else if (pick < 95) cmd = CMD_WRITE;
    else cmd = CMD_NONE;
    if ($urandom_range(9) < 8) begin
      case ($urandom_range(4))
        0:       off = OFF_DIV;
        1:       off = OFF_CNT;
        2:       off = OFF_MOD;
        3:       off = OFF_CTRL;
        default: off = OFF_FLAGS;
      endcase
    end else begin
      off = 4'($urandom_range(15));
    end
    wdata = 8'($urandom_range(255));
    // Keep the counter mostly running and often close to wrapping.
    if (cmd == CMD_WRITE && off == OFF_CTRL) wdata[CTRL_EN_BIT] = ($urandom_range(99) < 80);
    if (cmd == CMD_WRITE && off == OFF_CNT && $urandom_range(1) == 1) wdata[7:4] = 4'hF;
    ticks = 8'($urandom_range(255));
    send_word(cmd, off, wdata, ticks);
  endtask

  // Lowers valid after the last word and waits for every result to come back.
  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    while (timer_replies.size() != 0) @(posedge clk_i);
  endtask

  // Register access, wrap and reload, and the corner cases of the bus and timer.
  task automatic test_directed();
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    send_word(CMD_READ,  OFF_DIV,   8'h00, 8'h00);
    send_word(CMD_READ,  OFF_FLAGS, 8'h00, 8'h00);
    send_word(CMD_WRITE, OFF_CTRL,  8'hFF, 8'h00);
    send_word(CMD_READ,  OFF_CTRL,  8'h00, 8'h00);
    send_word(CMD_WRITE, OFF_MOD,   8'hFE, 8'h00);
    send_word(CMD_WRITE, OFF_CNT,   8'hFF, 8'h00);
    // A full-size tick just short of the period, then a tick of one to wrap the counter.
    send_word(CMD_TICK,  OFF_DIV,   8'h00, 8'hFF);
    send_word(CMD_TICK,  OFF_DIV,   8'h00, 8'h01);
    send_word(CMD_READ,  OFF_CNT,   8'h00, 8'h00);
    send_word(CMD_READ,  OFF_FLAGS, 8'h00, 8'h00);
    send_word(CMD_WRITE, OFF_FLAGS, 8'h13, 8'h00);
    send_word(CMD_READ,  OFF_FLAGS, 8'h00, 8'h00);
    // Writing the divider clears it whatever the data.
    send_word(CMD_WRITE, OFF_DIV,   8'hAB, 8'h00);
    send_word(CMD_READ,  OFF_DIV,   8'h00, 8'h00);
    // Unmapped offsets and the unused command change nothing.
    send_word(CMD_WRITE, 4'h3,      8'hFF, 8'hFF);
    send_word(CMD_READ,  4'h3,      8'hFF, 8'hFF);
    send_word(CMD_NONE,  OFF_CNT,   8'hFF, 8'hFF);
    // With the counter disabled its fraction must hold.
    send_word(CMD_WRITE, OFF_CTRL,  8'h00, 8'h00);
    send_word(CMD_TICK,  OFF_CNT,   8'h00, 8'hC8);
    // Build up a large fraction on the long period, then drain it on the short one.
    send_word(CMD_WRITE, OFF_CTRL,  8'h04, 8'h00);
    send_word(CMD_TICK,  OFF_CNT,   8'h00, 8'hFF);
    send_word(CMD_TICK,  OFF_CNT,   8'h00, 8'hFF);
    send_word(CMD_TICK,  OFF_CNT,   8'h00, 8'h00);
    send_word(CMD_WRITE, OFF_CTRL,  8'h05, 8'h00);
    send_word(CMD_TICK,  OFF_CNT,   8'h00, 8'hFF);
    send_word(CMD_READ,  OFF_CNT,   8'h00, 8'h00);
    finish_phase();
  endtask

  // Random traffic under one idling pattern.
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned count);
    send_idle_pct = idle_pct;
    rcv_stall_pct = stall_pct;
    repeat (count) send_random_word();
    finish_phase();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering words.
  task automatic test_backpressure();
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    fork
      begin
        rcv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rcv_hold <= 1'b0;
      end
    join_none
    repeat (24) send_random_word();
    finish_phase();
  endtask

  // Result checker and receiver stalls.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (timer_replies.size() == 0) begin
        $error("Result word 0x%0h arrived with nothing expected", m_axis_tdata);
        fail_count++;
      end else begin
        want_reply = timer_replies.pop_front();
        n_checked++;
        if (m_axis_tdata[7:0] !== want_reply.rd) begin
          $error("read_data: expected 0x%0h, got 0x%0h", want_reply.rd, m_axis_tdata[7:0]);
          fail_count++;
        end
        if (m_axis_tdata[8] !== want_reply.irq) begin
          $error("overflow_irq: expected %0b, got %0b", want_reply.irq, m_axis_tdata[8]);
          fail_count++;
        end
      end
    end
    m_axis_tready <= !rcv_hold && ($urandom_range(99) >= rcv_stall_pct);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("Timed out after %0d cycles with %0d results outstanding", cycle_count,
             timer_replies.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_READ;
    m_axis_tready = 1'b0;
    rcv_hold      = 1'b0;
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    cycle_count   = 0;
    n_sent        = 0;
    n_checked     = 0;
    n_wraps       = 0;
    fail_count    = 0;
    tm_div        = '0;
    tm_div_frac   = '0;
    tm_cnt        = '0;
    tm_cnt_frac   = '0;
    tm_mod        = '0;
    tm_ctrl       = '0;
    tm_flags      = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic(0, 0, 400);
    test_random_traffic(56, 0, 400);
    test_random_traffic(0, 56, 400);
    test_random_traffic(33, 33, 400);
    test_backpressure();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d words and checked %0d result words in %0d cycles.", n_sent, n_checked,
             cycle_count);
    $display("Counter wrapped on %0d ticks, across four idling patterns and a long stall.",
             n_wraps);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
